// ===== sv/mrsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running status assembler package
// Shared constants and types for the front end, message queue and back end.
// ----------------------------------------------------------------------------
package mrsa_pkg;

	localparam int unsigned MSG_BYTES   = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  CLOCK_BYTE  = 8'hF8;
	localparam logic [7:0]  SENSE_BYTE  = 8'hFE;
	localparam logic [15:0] TABLE_RESET = 16'h7AFF;

	localparam logic [1:0]  LEN_NONE    = 2'd0;

	// One complete message waiting to be sent: its length and its bytes,
	// the status byte first.
	typedef struct packed {
		logic [1:0]                  count;
		logic [MSG_BYTES-1:0][7:0]   bytes;
	} msg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage : mrsa_pkg
`default_nettype wire

// ===== sv/mrsa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running status assembler front end
// Takes one byte a beat while the queue has room, tracks running status and
// fill position, and hands each finished message to the queue.
// ----------------------------------------------------------------------------
module mrsa_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [15:0]       length_table,
	input  wire mrsa_pkg::q_stat_t q_stat,
	output logic                   push,
	output mrsa_pkg::msg_t         entry
);

	logic [15:0]      table_q;
	logic [7:0]       status_q;
	logic [1:0]       fill_q;
	logic [1:0][7:0]  held_q;

	logic             accept;
	logic             is_status;
	logic             is_drop;
	logic [1:0]       need;
	logic [1:0]       fill_eff;
	logic [1:0]       fill_inc;
	logic             slot;
	logic             take;
	logic             done;
	logic [1:0][7:0]  held_new;

	assign in_ready  = !q_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	always_comb begin
		is_status = data_byte[7];
		is_drop   = (data_byte == mrsa_pkg::CLOCK_BYTE) ||
			(data_byte == mrsa_pkg::SENSE_BYTE);
		need      = table_q[{status_q[6:4], 1'b0} +: 2];
		// A data byte after a completed message starts the next one under
		// the running status.
		fill_eff  = ((fill_q == 2'd0) && (status_q != 8'd0)) ? 2'd1 : fill_q;
		fill_inc  = fill_eff + 2'd1;
		slot      = ~fill_eff[0];
		take      = !is_status && (fill_eff != 2'd0);
		done      = (fill_inc == 2'd0) || (fill_inc >= need);
		held_new  = held_q;
		if (take) begin
			held_new[slot] = data_byte;
		end
		push        = accept && take && done && (need != mrsa_pkg::LEN_NONE);
		entry.count = need;
		entry.bytes = {held_new[1], held_new[0], status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q  <= mrsa_pkg::TABLE_RESET;
			status_q <= 8'd0;
			fill_q   <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_q <= length_table;
			end
			if (accept) begin
				if (is_status && !is_drop) begin
					status_q <= data_byte;
					fill_q   <= 2'd1;
				end else if (take) begin
					fill_q <= done ? 2'd0 : fill_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			held_q <= held_new;
		end
	end

endmodule : mrsa_front
`default_nettype wire

// ===== sv/mrsa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running status assembler message queue
// A short first-in first-out store of whole messages between front and back.
// ----------------------------------------------------------------------------
module mrsa_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mrsa_pkg::msg_t  entry,
	input  wire logic            pop,
	output mrsa_pkg::msg_t       head,
	output mrsa_pkg::q_stat_t    q_stat
);

	mrsa_pkg::msg_t                    mem [mrsa_pkg::QUEUE_DEPTH];
	logic [mrsa_pkg::QPTR_W-1:0]       wr_q;
	logic [mrsa_pkg::QPTR_W-1:0]       rd_q;
	logic [mrsa_pkg::QCNT_W-1:0]       cnt_q;

	assign head         = mem[rd_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == mrsa_pkg::QCNT_W'(mrsa_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == mrsa_pkg::QPTR_W'(mrsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == mrsa_pkg::QPTR_W'(mrsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= entry;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("message pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("message popped from an empty queue");
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> (head.count != mrsa_pkg::LEN_NONE))
		else $error("queued message carries no bytes");
`endif

endmodule : mrsa_queue
`default_nettype wire

// ===== sv/mrsa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running status assembler back end
// Sends the message at the head of the queue one byte a beat while the output
// is accepted, through an output register, and marks its final byte.
// ----------------------------------------------------------------------------
module mrsa_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mrsa_pkg::msg_t    head,
	input  wire mrsa_pkg::q_stat_t q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   last_of_run
);

	logic [1:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       is_last;
	logic [7:0] next_byte;

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_comb begin
		load    = !valid_q || out_ready;
		is_last = (pos_q == (head.count - 2'd1));
		pop     = load && !q_stat.empty && is_last;
		unique case (pos_q)
			2'd0:    next_byte = head.bytes[0];
			2'd1:    next_byte = head.bytes[1];
			2'd2:    next_byte = head.bytes[2];
			default: next_byte = head.bytes[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				pos_q <= is_last ? 2'd0 : pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

`ifndef SYNTHESIS
	a_pos_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> (pos_q < head.count))
		else $error("byte position beyond the queued message");
	a_pop_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pos_q == 2'd0) && valid_q && last_q)
		else $error("message end not marked or position not rewound");
`endif

endmodule : mrsa_back
`default_nettype wire

// ===== sv/midi_running_status_assembler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running status assembler
// Rebuilds complete MIDI channel messages from a byte stream with running
// status and sends each as a run of bytes with its final byte marked.
// ----------------------------------------------------------------------------
// The front end takes one received byte every cycle while the two-entry
// message queue has room; a byte that completes a message enters the queue
// as a whole message. The back end sends one message byte per cycle from the
// queue head through an output register while the output is accepted, and
// the front end can keep taking bytes for later messages while one is being
// sent. Timing clock and active sensing bytes are dropped, other status bytes
// set the running status, and the length of each message comes from the
// length table, which must be written through the configuration channel only
// while the block is idle; the block itself does not enforce this.
module midi_running_status_assembler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] length_table
);

	logic              push;
	logic              pop;
	mrsa_pkg::msg_t    entry;
	mrsa_pkg::msg_t    head;
	mrsa_pkg::q_stat_t q_stat;

	mrsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.length_table (length_table),
		.q_stat       (q_stat),
		.push         (push),
		.entry        (entry)
	);

	mrsa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	mrsa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule : midi_running_status_assembler
`default_nettype wire
